// File: rtl/core/rqsd_pkg.sv
// Shared types and constants for the radius query block.
package rqsd_pkg;

  localparam int MAX_POINTS_DEF = 32;
  localparam int ID_WIDTH_DEF   = 16;
  localparam int DSQ_W          = 34;
  localparam int ARR_W          = 6;
  localparam int DIST_W         = 17;

  localparam logic [1:0] REG_CX = 2'd0;
  localparam logic [1:0] REG_CY = 2'd1;
  localparam logic [1:0] REG_RAD = 2'd2;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [15:0]        player_id;
    logic               accepted;
    logic               last_point;
  } in_item_t;

  typedef struct packed {
    logic [4:0]        slot_index;
    logic [15:0]       out_player_id;
    logic [DIST_W-1:0] distance;
    logic              found;
    logic              overflow;
    logic              end_of_run;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_FILL,
    ST_SQRT,
    ST_SEND
  } state_t;

endpackage

// File: rtl/core/rqsd_cell.sv
// One cell of the sorted insertion chain.
module rqsd_cell #(
  parameter int ID_WIDTH = rqsd_pkg::ID_WIDTH_DEF,
  parameter int KW       = rqsd_pkg::DSQ_W + ID_WIDTH + rqsd_pkg::ARR_W
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          clear,
  input  logic          ins_vld,
  input  logic [KW-1:0] ins_key,
  input  logic          shift,
  input  logic          prev_vld,
  input  logic [KW-1:0] prev_key,
  input  logic          prev_moves,
  input  logic          next_vld,
  input  logic [KW-1:0] next_key,
  output logic          vld,
  output logic [KW-1:0] key,
  output logic          moves
);

  logic          vld_r, vld_nxt;
  logic [KW-1:0] key_r, key_nxt;

  // key is {dist_sq, id, arrival}, so plain compare gives the sort order;
  // an empty cell or one sorting strictly after the new key makes room
  assign moves = !vld_r || (key_r > ins_key);
  assign vld = vld_r;
  assign key = key_r;

  always_comb begin
    vld_nxt = vld_r;
    key_nxt = key_r;
    if (clear) begin
      vld_nxt = 1'b0;
    end else if (shift) begin
      // unload: take the entry behind, toward the head
      vld_nxt = next_vld;
      key_nxt = next_key;
    end else if (ins_vld && moves) begin
      if (prev_moves) begin
        // insertion point lies ahead: step back by one
        vld_nxt = prev_vld;
        key_nxt = prev_key;
      end else begin
        vld_nxt = 1'b1;
        key_nxt = ins_key;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
    key_r <= key_nxt;
  end

endmodule

// File: rtl/core/rqsd_sqrt.sv
// Iterative floor square root, two radicand bits and one result bit per cycle.
module rqsd_sqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [rqsd_pkg::DSQ_W-1:0]  value,
  output logic                        done,
  output logic [rqsd_pkg::DIST_W-1:0] root
);

  localparam int N = rqsd_pkg::DSQ_W;
  localparam int R = rqsd_pkg::DIST_W;

  logic [N-1:0] rem_r, rem_nxt;
  logic [R-1:0] res_r, res_nxt;
  logic [N-1:0] val_r, val_nxt;
  logic [4:0]   cnt_r, cnt_nxt;
  logic         busy_r, busy_nxt;
  logic [N+1:0] acc, trial;

  assign root = res_r;
  // held until the next start
  assign done = busy_r && (cnt_r == 5'd0);

  // restoring digit recurrence: bring down two bits, try 4*res+1
  always_comb begin
    rem_nxt  = rem_r;
    res_nxt  = res_r;
    val_nxt  = val_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    acc   = {rem_r, val_r[N-1:N-2]};
    trial = {{(N-R){1'b0}}, res_r, 2'b01};
    if (start) begin
      rem_nxt  = '0;
      res_nxt  = '0;
      val_nxt  = value;
      cnt_nxt  = 5'(R);
      busy_nxt = 1'b1;
    end else if (busy_r && cnt_r != 5'd0) begin
      val_nxt = {val_r[N-3:0], 2'b00};
      cnt_nxt = cnt_r - 5'd1;
      if (acc >= trial) begin
        rem_nxt = N'(acc - trial);
        res_nxt = {res_r[R-2:0], 1'b1};
      end else begin
        rem_nxt = N'(acc);
        res_nxt = {res_r[R-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    res_r <= res_nxt;
    val_r <= val_nxt;
  end

endmodule

// File: rtl/core/radius_query_sorted_by_distance.sv
// Top level of the radius query: distance front end, sorted cell chain, output side.
//
// Usage:
//  - Points enter on in_valid/in_ready (payload in_data), one transaction per cycle
//    while a set is filling. A point with accepted=1 and squared distance within
//    radius^2 is inserted, after the stage 1 register, into a row of MAX_POINTS
//    cells kept sorted by squared distance, id, arrival index, unless all are full.
//  - The last point closes the set; in_ready drops the cycle after it is accepted
//    and stays low until the final result of the set is loaded into the output
//    register.
//  - Unload pops the chain head: the square root is started, iterates once per
//    result bit, and its result is loaded into the output register once that is
//    free. An empty answer gives one found=0 result with end_of_run set.
//  - Results leave on out_valid/out_ready (payload out_data) from an output
//    register; a stalled receiver holds that register and the unload waits.
//  - Reset (rst_n low, synchronous) empties the chain and clears counters, state and
//    configuration. Configuration goes through the cfg_ APB port at byte addresses
//    0, 4, 8; the user must write it only while idle; the block does not enforce this.
module radius_query_sorted_by_distance #(
  parameter int MAX_POINTS = rqsd_pkg::MAX_POINTS_DEF,
  parameter int ID_WIDTH   = rqsd_pkg::ID_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  rqsd_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output rqsd_pkg::out_item_t out_data,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [3:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);

  localparam int DW = rqsd_pkg::DSQ_W;
  localparam int AW = rqsd_pkg::ARR_W;
  localparam int KW = DW + ID_WIDTH + AW;
  localparam int CW = $clog2(MAX_POINTS + 1);

  // configuration registers
  logic [15:0] cx_r, cy_r, rad_r;
  logic        cfg_wr;
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r  <= '0;
      cy_r  <= '0;
      rad_r <= '0;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        rqsd_pkg::REG_CX:  cx_r  <= cfg_pwdata[15:0];
        rqsd_pkg::REG_CY:  cy_r  <= cfg_pwdata[15:0];
        rqsd_pkg::REG_RAD: rad_r <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    case (cfg_paddr[3:2])
      rqsd_pkg::REG_CX:  cfg_prdata = {16'd0, cx_r};
      rqsd_pkg::REG_CY:  cfg_prdata = {16'd0, cy_r};
      rqsd_pkg::REG_RAD: cfg_prdata = {16'd0, rad_r};
      default:           cfg_prdata = '0;
    endcase
  end

  // stage 1: differences and squares, registered
  logic signed [16:0] dx, dy;
  logic [16:0]        ax, ay;
  logic [DW-1:0]      sx_r, sy_r;
  logic [31:0]        r2_r;
  rqsd_pkg::in_item_t s1_r;
  logic               s1_vld_r;
  logic [AW-1:0]      arr_r, s1_arr_r;
  logic               in_acc;

  assign dx = 17'(in_data.pos_x) - 17'(signed'(cx_r));
  assign dy = 17'(in_data.pos_y) - 17'(signed'(cy_r));
  assign ax = dx[16] ? 17'(-dx) : 17'(dx);
  assign ay = dy[16] ? 17'(-dy) : 17'(dy);

  rqsd_pkg::state_t st_r, st_nxt;
  assign in_ready = (st_r == rqsd_pkg::ST_FILL) && !(s1_vld_r && s1_r.last_point);
  assign in_acc = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_acc;
    end
    sx_r     <= DW'(ax * ax);
    sy_r     <= DW'(ay * ay);
    r2_r     <= rad_r * rad_r;
    s1_r     <= in_data;
    s1_arr_r <= arr_r;
  end

  // stage 2: qualify and insert into the chain
  logic [DW-1:0]       d2;
  logic                hit, ins;
  logic [CW-1:0]       kept_r, kept_nxt;
  logic                drop_r, drop_nxt;
  logic [KW-1:0]       ins_key;
  logic                clr, shift;
  logic [ID_WIDTH-1:0] id_m;

  assign d2  = sx_r + sy_r;
  assign hit = s1_vld_r && s1_r.accepted && (d2 <= DW'(r2_r));
  assign ins = hit && (kept_r != CW'(MAX_POINTS));
  assign id_m = ID_WIDTH'(s1_r.player_id);
  assign ins_key = {d2, id_m, s1_arr_r};

  logic [MAX_POINTS-1:0] c_vld, c_mov;
  logic [KW-1:0]         c_key [MAX_POINTS];

  for (genvar g = 0; g < MAX_POINTS; g++) begin : g_cell
    logic          pv, pm, nv;
    logic [KW-1:0] pk, nk;
    if (g == 0) begin : g_head
      assign pv = 1'b0;
      assign pk = '0;
      assign pm = 1'b0;
    end else begin : g_body
      assign pv = c_vld[g-1];
      assign pk = c_key[g-1];
      assign pm = c_mov[g-1];
    end
    if (g == MAX_POINTS - 1) begin : g_tail
      assign nv = 1'b0;
      assign nk = '0;
    end else begin : g_link
      assign nv = c_vld[g+1];
      assign nk = c_key[g+1];
    end
    rqsd_cell #(.ID_WIDTH(ID_WIDTH), .KW(KW)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .clear     (clr),
      .ins_vld   (ins),
      .ins_key   (ins_key),
      .shift     (shift),
      .prev_vld  (pv),
      .prev_key  (pk),
      .prev_moves(pm),
      .next_vld  (nv),
      .next_key  (nk),
      .vld       (c_vld[g]),
      .key       (c_key[g]),
      .moves     (c_mov[g])
    );
  end

  // unload side: chain head, sqrt, output register
  logic [CW-1:0]       rd_r, rd_nxt;
  logic                sq_start, sq_done;
  logic [rqsd_pkg::DIST_W-1:0] sq_root;
  logic [KW-1:0]       cur_key;
  logic                ov_r, ov_nxt;
  logic                o_vld_r, o_vld_nxt;
  rqsd_pkg::out_item_t o_r, o_nxt;
  logic [CW-1:0]       nk_r, nk_nxt;

  assign cur_key = c_key[0];

  rqsd_sqrt u_sqrt (
    .clk  (clk),
    .rst_n(rst_n),
    .start(sq_start),
    .value(cur_key[KW-1 -: DW]),
    .done (sq_done),
    .root (sq_root)
  );

  always_comb begin
    st_nxt    = st_r;
    kept_nxt  = kept_r;
    drop_nxt  = drop_r;
    rd_nxt    = rd_r;
    ov_nxt    = ov_r;
    nk_nxt    = nk_r;
    o_vld_nxt = o_vld_r;
    o_nxt     = o_r;
    sq_start  = 1'b0;
    clr       = 1'b0;
    shift     = 1'b0;
    if (o_vld_r && out_ready) o_vld_nxt = 1'b0;
    case (st_r)
      rqsd_pkg::ST_FILL: begin
        if (ins) kept_nxt = kept_r + CW'(1);
        if (hit && !ins) drop_nxt = 1'b1;
        if (s1_vld_r && s1_r.last_point) begin
          ov_nxt   = drop_nxt;
          nk_nxt   = kept_nxt;
          rd_nxt   = '0;
          kept_nxt = '0;
          drop_nxt = 1'b0;
          st_nxt   = rqsd_pkg::ST_SQRT;
        end
      end
      rqsd_pkg::ST_SQRT: begin
        if (nk_r == '0) begin
          if (!o_vld_nxt) begin
            o_vld_nxt = 1'b1;
            o_nxt = '{slot_index: '0, out_player_id: '0, distance: '0,
                      found: 1'b0, overflow: ov_r, end_of_run: 1'b1};
            clr    = 1'b1;
            st_nxt = rqsd_pkg::ST_FILL;
          end
        end else begin
          sq_start = 1'b1;
          st_nxt   = rqsd_pkg::ST_SEND;
        end
      end
      rqsd_pkg::ST_SEND: begin
        if (sq_done && !o_vld_nxt) begin
          o_vld_nxt = 1'b1;
          o_nxt.slot_index    = cur_key[4:0];
          o_nxt.out_player_id = 16'(cur_key[AW +: ID_WIDTH]);
          o_nxt.distance      = sq_root;
          o_nxt.found         = 1'b1;
          o_nxt.overflow      = ov_r;
          o_nxt.end_of_run    = (rd_r + CW'(1) == nk_r);
          rd_nxt = rd_r + CW'(1);
          // pop the head entry
          shift  = 1'b1;
          if (rd_r + CW'(1) == nk_r) begin
            clr    = 1'b1;
            st_nxt = rqsd_pkg::ST_FILL;
          end else begin
            st_nxt = rqsd_pkg::ST_SQRT;
          end
        end
      end
      default: st_nxt = rqsd_pkg::ST_FILL;
    endcase
  end

  // arrival counter saturates at its top value and restarts at zero after the last point
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arr_r <= '0;
    end else if (in_acc) begin
      if (in_data.last_point) arr_r <= '0;
      else if (arr_r != '1) arr_r <= arr_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= rqsd_pkg::ST_FILL;
      kept_r  <= '0;
      drop_r  <= 1'b0;
      rd_r    <= '0;
      ov_r    <= 1'b0;
      nk_r    <= '0;
      o_vld_r <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      kept_r  <= kept_nxt;
      drop_r  <= drop_nxt;
      rd_r    <= rd_nxt;
      ov_r    <= ov_nxt;
      nk_r    <= nk_nxt;
      o_vld_r <= o_vld_nxt;
    end
    o_r <= o_nxt;
  end

  assign out_valid = o_vld_r;
  assign out_data  = o_r;

endmodule

// File: dv/radius_query_sorted_by_distance_checker.sv
// Checker for the radius query: tracks configuration, predicts sorted results, compares.
module radius_query_sorted_by_distance_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  rqsd_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  rqsd_pkg::out_item_t out_data,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic                cfg_pready,
  input  logic [3:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output int                  fail_count,
  output int                  pending_count
);

  localparam int CAP = rqsd_pkg::MAX_POINTS_DEF;

  typedef struct {
    logic [rqsd_pkg::DSQ_W-1:0] dsq;
    logic [15:0]                id;
    logic [rqsd_pkg::ARR_W-1:0] arr;
  } kept_pt_t;

  logic signed [15:0]         cx, cy;
  logic [15:0]                rad;
  kept_pt_t                   near_set[$];
  logic [rqsd_pkg::ARR_W-1:0] arrival;
  logic                       dropped;
  rqsd_pkg::out_item_t        answer_q[$];

  assign pending_count = answer_q.size();

  // integer floor square root by bit search
  function automatic logic [rqsd_pkg::DIST_W-1:0] isqrt(logic [rqsd_pkg::DSQ_W-1:0] v);
    logic [rqsd_pkg::DIST_W-1:0] r;
    r = '0;
    for (int b = rqsd_pkg::DIST_W - 1; b >= 0; b--) begin
      logic [rqsd_pkg::DIST_W-1:0] t;
      t = r | (rqsd_pkg::DIST_W'(1) << b);
      if ({17'd0, t} * {17'd0, t} <= {1'b0, v}) r = t;
    end
    return r;
  endfunction

  // "a sorts strictly after b"
  function automatic bit sorts_after(kept_pt_t a, kept_pt_t b);
    if (a.dsq != b.dsq) return a.dsq > b.dsq;
    if (a.id != b.id) return a.id > b.id;
    return a.arr > b.arr;
  endfunction

  task automatic take_point(rqsd_pkg::in_item_t p);
    int dx, dy, pos;
    logic [rqsd_pkg::DSQ_W-1:0] d2, r2;
    kept_pt_t e;
    rqsd_pkg::out_item_t o;
    dx = int'(p.pos_x) - int'(cx);
    dy = int'(p.pos_y) - int'(cy);
    d2 = rqsd_pkg::DSQ_W'(longint'(dx) * dx + longint'(dy) * dy);
    r2 = rqsd_pkg::DSQ_W'(longint'(rad) * rad);
    e.arr = arrival;
    if (arrival < 63) arrival++;
    if (p.accepted && d2 <= r2) begin
      if (near_set.size() >= CAP) dropped = 1'b1;
      else begin
        e.dsq = d2;
        e.id = p.player_id;
        pos = near_set.size();
        while (pos > 0 && sorts_after(near_set[pos-1], e)) pos--;
        near_set.insert(pos, e);
      end
    end
    if (!p.last_point) return;
    if (near_set.size() == 0) begin
      o = '0;
      o.overflow = dropped;
      o.end_of_run = 1'b1;
      answer_q = {answer_q, o};
    end else begin
      foreach (near_set[k]) begin
        o.slot_index = near_set[k].arr[4:0];
        o.out_player_id = near_set[k].id;
        o.distance = isqrt(near_set[k].dsq);
        o.found = 1'b1;
        o.overflow = dropped;
        o.end_of_run = (k == near_set.size() - 1);
        answer_q = {answer_q, o};
      end
    end
    near_set.delete();
    arrival = '0;
    dropped = 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      cx <= '0; cy <= '0; rad <= '0;
      arrival = '0;
      dropped = 1'b0;
      near_set.delete();
      answer_q.delete();
      fail_count <= 0;
    end else begin
      // register writes
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[3:2])
          rqsd_pkg::REG_CX:  cx <= cfg_pwdata[15:0];
          rqsd_pkg::REG_CY:  cy <= cfg_pwdata[15:0];
          rqsd_pkg::REG_RAD: rad <= cfg_pwdata[15:0];
          default: ;
        endcase
      end
      // result transaction
      if (out_valid && out_ready) begin
        if (answer_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %p", $time, out_data);
          fail_count <= fail_count + 1;
        end else begin
          rqsd_pkg::out_item_t x;
          x = answer_q.pop_front();
          if (x !== out_data) begin
            $display("%0t: result mismatch, expected %p, actual %p", $time, x, out_data);
            fail_count <= fail_count + 1;
          end
        end
      end
      // input transaction
      if (in_valid && in_ready) take_point(in_data);
    end
  end

endmodule

// File: dv/radius_query_sorted_by_distance_test.sv
// Testbench top for the radius query: stimulus, configuration phases and verdict.
module radius_query_sorted_by_distance_test;

  localparam int IDLE_LIMIT = 20000;

  logic                clk, rst_n;
  logic                in_valid, in_ready, out_valid, out_ready;
  rqsd_pkg::in_item_t  in_data;
  rqsd_pkg::out_item_t out_data;
  logic                cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [3:0]          cfg_paddr;
  logic [31:0]         cfg_pwdata, cfg_prdata;
  int                  fail_count, pending_count;
  int                  send_idle_pct, recv_idle_pct;
  int                  quiet_cycles;

  radius_query_sorted_by_distance u_dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_prdata,
    .cfg_pready
  );

  radius_query_sorted_by_distance_checker u_chk (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_pready, .cfg_paddr, .cfg_pwdata,
    .fail_count, .pending_count
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // receiver stalls
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // watchdog on cycles with no transaction
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("radius_query_sorted_by_distance regression: fail");
      $finish;
    end
  end

  task automatic reg_write(logic [1:0] idx, logic [15:0] val);
    cfg_psel <= 1'b1; cfg_penable <= 1'b0; cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00}; cfg_pwdata <= {16'd0, val};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
  endtask

  task automatic set_query(logic [15:0] x, logic [15:0] y, logic [15:0] r);
    reg_write(rqsd_pkg::REG_CX, x);
    reg_write(rqsd_pkg::REG_CY, y);
    reg_write(rqsd_pkg::REG_RAD, r);
  endtask

  // wait for all results, then the block's settling time
  task automatic drain();
    while (pending_count != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // one point transaction with optional sender gap before it
  task automatic send_point(logic signed [15:0] x, logic signed [15:0] y, logic [15:0] id,
                            logic acc, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{pos_x: x, pos_y: y, player_id: id, accepted: acc, last_point: last};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic end_burst();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // random query set; point spread scales with the radius
  task automatic random_set(int n, int spread);
    int cxv, cyv;
    cxv = $signed(u_chk.cx); cyv = $signed(u_chk.cy);
    for (int i = 0; i < n; i++) begin
      logic signed [15:0] px, py;
      logic [15:0] pid;
      if ($urandom_range(9) < 2) begin
        px = 16'($urandom); py = 16'($urandom);
      end else begin
        px = 16'(cxv + $signed($urandom_range(2*spread)) - spread);
        py = 16'(cyv + $signed($urandom_range(2*spread)) - spread);
      end
      pid = ($urandom_range(3) == 0) ? 16'($urandom_range(3)) : 16'($urandom);
      send_point(px, py, pid, $urandom_range(9) != 0, i == n - 1);
    end
    end_burst();
  endtask

  initial begin
    int done;
    rst_n = 1'b0; in_valid = 1'b0; in_data = '0;
    cfg_psel = 1'b0; cfg_penable = 1'b0; cfg_pwrite = 1'b0;
    cfg_paddr = '0; cfg_pwdata = '0;
    send_idle_pct = 9; recv_idle_pct = 68;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty answer with zero radius and reset centre
    send_point(16'sd5, 16'sd0, 16'd1, 1'b1, 1'b1);
    end_burst(); drain();
    // centre and point at opposite extremes, full radius
    set_query(16'h8000, 16'h8000, 16'hFFFF);
    send_point(16'sh7FFF, 16'sh7FFF, 16'hFFFF, 1'b1, 1'b0);
    send_point(16'sh8000, 16'sh8000, 16'h0000, 1'b1, 1'b0);
    send_point(16'sh7FFF, 16'sh8000, 16'h1234, 1'b0, 1'b0);
    send_point(16'sh0000, 16'sh7FFF, 16'h00FF, 1'b1, 1'b1);
    end_burst(); drain();
    // inclusive boundary, ties on distance and id, unaccepted points
    set_query(16'sd0, 16'sd0, 16'd100);
    send_point(16'sd100, 16'sd0, 16'd7, 1'b1, 1'b0);
    send_point(16'sd101, 16'sd0, 16'd7, 1'b1, 1'b0);
    send_point(16'sd0, -16'sd100, 16'd7, 1'b1, 1'b0);
    send_point(16'sd60, 16'sd80, 16'd3, 1'b1, 1'b0);
    send_point(16'sd1, 16'sd1, 16'd9, 1'b0, 1'b0);
    send_point(16'sd0, 16'sd0, 16'd9, 1'b1, 1'b1);
    end_burst(); drain();
    // last point unaccepted leaves an empty answer
    send_point(16'sd0, 16'sd0, 16'd2, 1'b0, 1'b1);
    end_burst(); drain();
    // store overflow and arrival saturation with one long set
    set_query(16'sd0, 16'sd0, 16'hFFFF);
    random_set(70, 2000);
    drain();

    // random phases: sender idle 9 / receiver 68, then swapped, then none
    done = 0;
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 9 : (ph == 1) ? 68 : 0;
      recv_idle_pct = (ph == 0) ? 68 : (ph == 1) ? 9 : 0;
      for (int s = 0; s < 12; s++) begin
        int n, r;
        r = (s % 4 == 0) ? 0 : (s % 4 == 1) ? 16'hFFFF : $urandom_range(4000);
        set_query(16'($urandom), 16'($urandom), 16'(r));
        n = (s % 6 == 5) ? $urandom_range(33, 40) : $urandom_range(1, 8);
        random_set(n, (r == 0) ? 2 : r + 50);
        done += n;
        if ($urandom_range(1)) drain();
        else while (pending_count != 0) @(posedge clk);
      end
      drain();
    end

    if (fail_count == 0) $display("radius_query_sorted_by_distance regression: pass");
    else $display("radius_query_sorted_by_distance regression: fail");
    $finish;
  end

endmodule
